// ===== rtl/pcfts_pkg.sv =====
`timescale 1ns / 1ps

package pcfts_pkg;

  localparam int NUM_CATEGORIES_DEF = 16;
  localparam int NUM_FRAMES_DEF     = 8;

  localparam int CAT_IN_W = 4;
  localparam int DUR_W    = 32;
  localparam int CNT_W    = 32;
  localparam int TOTAL_W  = 48;
  localparam int ACT_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CNT_W-1:0]   ONES32 = '1;
  localparam logic [TOTAL_W-1:0] ONES48 = '1;

  // Register indexes, as selected by the word address.
  localparam logic REG_ACTIVE_CATEGORIES = 1'b0;

  // Division by one million: floor(x / 1e6) == ((x >> 6) * RECIP) >> 40 for 32-bit x.
  localparam int MS_PRE_SHIFT = 6;
  localparam int MS_RECIP_W   = 27;
  localparam int MS_SHIFT     = 40;
  localparam int MS_PROD_W    = DUR_W - MS_PRE_SHIFT + MS_RECIP_W;
  localparam int MS_Q_W       = MS_PROD_W - MS_SHIFT;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = 27'd70368745;

  typedef struct packed {
    logic [CNT_W-1:0]   calls;
    logic [TOTAL_W-1:0] total;
    logic [DUR_W-1:0]   lo_ns;
    logic [DUR_W-1:0]   hi_ns;
  } stat_t;

  localparam stat_t STAT_CLEAR = '{calls: '0, total: '0, lo_ns: '1, hi_ns: '0};

  typedef enum logic [1:0] {
    OP_INC_SAT,
    OP_ADD_SAT,
    OP_MIN,
    OP_MAX
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [TOTAL_W-1:0] a;
    logic [TOTAL_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRAME_WALK,
    ST_READ,
    ST_LOAD,
    ST_PREV,
    ST_S_CALLS,
    ST_S_TOTAL,
    ST_S_MIN,
    ST_S_MAX,
    ST_C_CALLS,
    ST_C_TOTAL,
    ST_C_MIN,
    ST_C_MAX,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/pcfts_alu.sv =====
`timescale 1ns / 1ps

module pcfts_alu (
  input  pcfts_pkg::alu_req_t                req,
  output logic [pcfts_pkg::TOTAL_W-1:0]      res
);
  import pcfts_pkg::*;

  logic               sub;
  logic [TOTAL_W:0]   opb;
  logic [TOTAL_W:0]   sum;
  logic               a_lt_b;

  always_comb begin
    sub    = (req.op == OP_MIN) || (req.op == OP_MAX);
    opb    = sub ? ~{1'b0, req.b} : {1'b0, req.b};
    sum    = {1'b0, req.a} + opb + (TOTAL_W + 1)'(sub);
    a_lt_b = sum[TOTAL_W];
    case (req.op)
      OP_INC_SAT: res = (sum[TOTAL_W:CNT_W] != '0) ? TOTAL_W'(ONES32) : sum[TOTAL_W-1:0];
      OP_ADD_SAT: res = sum[TOTAL_W] ? ONES48 : sum[TOTAL_W-1:0];
      OP_MIN:     res = a_lt_b ? req.a : req.b;
      OP_MAX:     res = a_lt_b ? req.b : req.a;
      default:    res = req.a;
    endcase
  end

endmodule

// ===== rtl/pcfts_ms_conv.sv =====
`timescale 1ns / 1ps

module pcfts_ms_conv (
  input  logic                             clk,
  input  logic [pcfts_pkg::DUR_W-1:0]      dur_ns,
  output logic [pcfts_pkg::MS_Q_W-1:0]     dur_ms
);
  import pcfts_pkg::*;

  logic [MS_PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MS_PROD_W'(dur_ns[DUR_W-1:MS_PRE_SHIFT]) * MS_PROD_W'(MS_RECIP);
  end

  assign dur_ms = prod_r[MS_PROD_W-1:MS_SHIFT];

endmodule

// ===== rtl/per_category_frame_timing_stats.sv =====
`timescale 1ns / 1ps
// Accepted sample: read, load, previous-frame fetch, eight dependent updates through
// the one shared add/compare unit, table write and result; the next sample is taken
// only once the result is loaded, which out_stall can hold off. Rejected sample: no
// updates and no write. Frame beat: a clear walk over the single write port of the
// slot table, one entry per category. Synchronous active-low reset; afterwards the
// tables are cleared over all NUM_CATEGORIES * NUM_FRAMES entries, in_stall high.

module per_category_frame_timing_stats #(
  parameter int NUM_CATEGORIES = pcfts_pkg::NUM_CATEGORIES_DEF,
  parameter int NUM_FRAMES     = pcfts_pkg::NUM_FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [pcfts_pkg::CAT_IN_W-1:0]     in_category,
  input  logic [pcfts_pkg::DUR_W-1:0]        in_duration_ns,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [$clog2(NUM_FRAMES)-1:0]      out_frame_slot,
  output logic [pcfts_pkg::CNT_W-1:0]        out_frame_calls,
  output logic [pcfts_pkg::TOTAL_W-1:0]      out_frame_total_ns,
  output logic [pcfts_pkg::DUR_W-1:0]        out_frame_min_ns,
  output logic [pcfts_pkg::DUR_W-1:0]        out_frame_max_ns,
  output logic [pcfts_pkg::CNT_W-1:0]        out_overall_calls,
  output logic [pcfts_pkg::TOTAL_W-1:0]      out_overall_total_ms,
  output logic [pcfts_pkg::DUR_W-1:0]        out_overall_min_ns,
  output logic [pcfts_pkg::DUR_W-1:0]        out_overall_max_ns,
  output logic [pcfts_pkg::TOTAL_W-1:0]      out_previous_frame_total_ns,
  output logic                               out_rejected,

  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pcfts_pkg::APB_AW-1:0]       cfg_paddr,
  input  logic [pcfts_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [pcfts_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                               cfg_pready
);
  import pcfts_pkg::*;

  localparam int SLOT_W = $clog2(NUM_FRAMES);
  localparam int CAT_W  = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int DEPTH  = NUM_CATEGORIES * NUM_FRAMES;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] slot_index(input logic [CAT_W-1:0] c,
                                                   input logic [SLOT_W-1:0] s);
    return ADDR_W'(int'(c) * NUM_FRAMES + int'(s));
  endfunction

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                out_valid_r;
  logic [ACT_W-1:0]    active_r;

  logic                cat_ok_r, upd_r, rej_r;
  logic [CAT_W-1:0]    cat_r;
  logic [DUR_W-1:0]    dur_r;

  stat_t               slot_mem [DEPTH];
  stat_t               cat_mem [NUM_CATEGORIES];
  stat_t               slot_q_r, cat_q_r;
  logic                slot_we, cat_we;
  logic [ADDR_W-1:0]   slot_waddr, slot_raddr;
  logic [CAT_W-1:0]    cat_waddr;
  stat_t               slot_wdata, cat_wdata;

  stat_t               w_r, c_r;
  logic [TOTAL_W-1:0]  prev_r;

  alu_req_t            alu_req;
  logic [TOTAL_W-1:0]  alu_res;
  logic [MS_Q_W-1:0]   dur_ms;

  logic                in_acc, out_load, cfg_wr, cat_ok, cat_rej;
  logic [SLOT_W-1:0]   prev_slot;
  logic [ADDR_W-1:0]   cur_addr;

  logic [SLOT_W-1:0]   o_slot_r;
  stat_t               o_frame_r, o_cat_r;
  logic [TOTAL_W-1:0]  o_prev_r;
  logic                o_rej_r;

  pcfts_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  pcfts_ms_conv u_ms_conv (
    .clk    (clk),
    .dur_ns (dur_r),
    .dur_ms (dur_ms)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cat_ok   = 32'(in_category) < NUM_CATEGORIES;
  assign cat_rej  = !cat_ok || ({1'b0, in_category} >= active_r);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[APB_AW-1] == REG_ACTIVE_CATEGORIES);
  assign cfg_prdata = (cfg_paddr[APB_AW-1] == REG_ACTIVE_CATEGORIES) ?
                      APB_DW'(active_r) : '0;

  assign prev_slot = (slot_r == '0) ? SLOT_W'(NUM_FRAMES - 1) : slot_r - 1'b1;
  assign cur_addr  = slot_index(cat_r, slot_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    slot_nxt   = slot_r;
    slot_we    = 1'b0;
    cat_we     = 1'b0;
    slot_waddr = cur_addr;
    slot_raddr = cur_addr;
    cat_waddr  = cat_r;
    slot_wdata = w_r;
    cat_wdata  = c_r;
    alu_req    = '{op: OP_INC_SAT, a: '0, b: '0};
    out_load   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = cnt_r;
        slot_wdata = STAT_CLEAR;
        cat_we     = 32'(cnt_r) < NUM_CATEGORIES;
        cat_waddr  = CAT_W'(cnt_r);
        cat_wdata  = STAT_CLEAR;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode) begin
            slot_nxt  = (slot_r == SLOT_W'(NUM_FRAMES - 1)) ? '0 : slot_r + 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_FRAME_WALK;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_FRAME_WALK: begin
        slot_we    = 1'b1;
        slot_waddr = slot_index(CAT_W'(cnt_r), slot_r);
        slot_wdata = STAT_CLEAR;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(NUM_CATEGORIES - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        slot_raddr = slot_index(cat_r, prev_slot);
        state_nxt  = ST_PREV;
      end
      ST_PREV: begin
        state_nxt = upd_r ? ST_S_CALLS : ST_DONE;
      end
      ST_S_CALLS: begin
        alu_req   = '{op: OP_INC_SAT, a: TOTAL_W'(w_r.calls), b: TOTAL_W'(1)};
        state_nxt = ST_S_TOTAL;
      end
      ST_S_TOTAL: begin
        alu_req   = '{op: OP_ADD_SAT, a: w_r.total, b: TOTAL_W'(dur_r)};
        state_nxt = ST_S_MIN;
      end
      ST_S_MIN: begin
        alu_req   = '{op: OP_MIN, a: TOTAL_W'(w_r.lo_ns), b: TOTAL_W'(dur_r)};
        state_nxt = ST_S_MAX;
      end
      ST_S_MAX: begin
        alu_req   = '{op: OP_MAX, a: TOTAL_W'(w_r.hi_ns), b: TOTAL_W'(dur_r)};
        state_nxt = ST_C_CALLS;
      end
      ST_C_CALLS: begin
        alu_req   = '{op: OP_INC_SAT, a: TOTAL_W'(c_r.calls), b: TOTAL_W'(1)};
        state_nxt = ST_C_TOTAL;
      end
      ST_C_TOTAL: begin
        alu_req   = '{op: OP_ADD_SAT, a: c_r.total, b: TOTAL_W'(dur_ms)};
        state_nxt = ST_C_MIN;
      end
      ST_C_MIN: begin
        alu_req   = '{op: OP_MIN, a: TOTAL_W'(c_r.lo_ns), b: TOTAL_W'(dur_r)};
        state_nxt = ST_C_MAX;
      end
      ST_C_MAX: begin
        alu_req   = '{op: OP_MAX, a: TOTAL_W'(c_r.hi_ns), b: TOTAL_W'(dur_r)};
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        slot_we   = 1'b1;
        cat_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      active_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        active_r <= cfg_pwdata[ACT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (cat_we) begin
      cat_mem[cat_waddr] <= cat_wdata;
    end
    cat_q_r <= cat_mem[cat_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cat_ok_r <= cat_ok;
      upd_r    <= !in_mode && !cat_rej;
      rej_r    <= !in_mode && cat_rej;
      cat_r    <= cat_ok ? CAT_W'(in_category) : '0;
      dur_r    <= in_duration_ns;
    end
    case (state_r)
      ST_LOAD: begin
        w_r <= slot_q_r;
        c_r <= cat_q_r;
      end
      ST_PREV:    prev_r        <= slot_q_r.total;
      ST_S_CALLS: w_r.calls     <= alu_res[CNT_W-1:0];
      ST_S_TOTAL: w_r.total     <= alu_res;
      ST_S_MIN:   w_r.lo_ns     <= alu_res[DUR_W-1:0];
      ST_S_MAX:   w_r.hi_ns     <= alu_res[DUR_W-1:0];
      ST_C_CALLS: c_r.calls     <= alu_res[CNT_W-1:0];
      ST_C_TOTAL: c_r.total     <= alu_res;
      ST_C_MIN:   c_r.lo_ns     <= alu_res[DUR_W-1:0];
      ST_C_MAX:   c_r.hi_ns     <= alu_res[DUR_W-1:0];
      default: begin
      end
    endcase
    if (out_load) begin
      o_slot_r <= slot_r;
      o_rej_r  <= rej_r;
      if (cat_ok_r) begin
        o_frame_r <= w_r;
        o_cat_r   <= c_r;
        o_prev_r  <= (active_r < ACT_W'(2)) ? '0 : prev_r;
      end else begin
        o_frame_r <= STAT_CLEAR;
        o_cat_r   <= STAT_CLEAR;
        o_prev_r  <= '0;
      end
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_frame_slot              = o_slot_r;
  assign out_frame_calls             = o_frame_r.calls;
  assign out_frame_total_ns          = o_frame_r.total;
  assign out_frame_min_ns            = o_frame_r.lo_ns;
  assign out_frame_max_ns            = o_frame_r.hi_ns;
  assign out_overall_calls           = o_cat_r.calls;
  assign out_overall_total_ms        = o_cat_r.total;
  assign out_overall_min_ns          = o_cat_r.lo_ns;
  assign out_overall_max_ns          = o_cat_r.hi_ns;
  assign out_previous_frame_total_ns = o_prev_r;
  assign out_rejected                = o_rej_r;

  // A new result beat is only ever raised by the final sequencer step.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the final step");

  // The clearing pass runs only right after reset, when nothing is pending.
  a_clear_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r && in_stall)
    else $error("clearing pass overlaps traffic");

  // The frame slot moves only on an accepted frame beat.
  a_slot_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_acc && in_mode) |-> $stable(slot_r))
    else $error("frame slot moved without a frame beat");

  // Table writes of the update path happen only for accepted, unrejected samples.
  a_write_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> upd_r && !rej_r)
    else $error("table write for a rejected or frame beat");

endmodule
